@@ hw/rtl/i2crt_pkg.sv @@
// Types and constants shared by the I2C register transaction master.
`timescale 1ns / 1ps

package i2crt_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam int unsigned PHASE_W = 10;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_START0 = 4'd1,
        ST_START1 = 4'd2,
        ST_START2 = 4'd3,
        ST_START3 = 4'd4,
        ST_BIT0   = 4'd5,
        ST_BIT1   = 4'd6,
        ST_BIT2   = 4'd7,
        ST_ACK0   = 4'd8,
        ST_ACK1   = 4'd9,
        ST_ACK2   = 4'd10,
        ST_STOP0  = 4'd11,
        ST_STOP1  = 4'd12,
        ST_STOP2  = 4'd13
    } t_seq_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [15:0] write_data;
        logic        sda_in;
    } t_in_item;

    typedef struct packed {
        logic        scl_release;
        logic        sda_release;
        logic        busy_res;
        logic        done_res;
        logic        nack;
        logic [15:0] read_data;
    } t_out_item;

endpackage

@@ hw/rtl/i2crt_if.sv @@
// Valid/ready stream interfaces for the tick input and the line result channels.
`timescale 1ns / 1ps

interface i2crt_in_if
    import i2crt_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2crt_out_if
    import i2crt_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/i2c_register_transaction_master.sv @@
// I2C master sequencing one register read or write transaction, one line tick per transfer.
// A tick's result is registered in the output register, or in the skid stage on a stall.
// Throughput: one tick per clock with an empty skid; a sequencer step is one logic pass.
// An output register plus a one-entry skid stage keep input accepting while a result waits.
// Reset (synchronous, active low) idles the sequencer, clears nack and read data, sets
// the phase length to one and empties the output stages.
`timescale 1ns / 1ps

module i2c_register_transaction_master
    import i2crt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [PHASE_W-1:0]   i_cfg_wdata,
    i2crt_in_if.sink             i_in,
    i2crt_out_if.source          o_out
);

    // configuration
    logic [PHASE_W-1:0] r_phase_len;

    // sequencer state
    t_seq_state         r_state,       n_state;
    logic [PHASE_W-1:0] r_phase_count, n_phase_count;
    logic [3:0]         r_bit_count,   n_bit_count;
    logic [2:0]         r_byte_index,  n_byte_index;
    logic [7:0]         r_shift,       n_shift;
    logic [6:0]         r_addr,        n_addr;
    logic [7:0]         r_reg,         n_reg;
    logic [15:0]        r_word,        n_word;
    logic [15:0]        r_read_word,   n_read_word;
    logic               r_nack,        n_nack;
    logic               r_is_write,    n_is_write;
    logic               n_done;

    // output stages
    logic               r_out_valid;
    t_out_item          r_out_data;
    logic               r_skid_valid;
    t_out_item          r_skid_data;

    logic               w_in_fire;
    logic               w_out_fire;
    logic [PHASE_W-1:0] w_len;
    logic               w_rx;
    logic               w_n_rx;
    logic               w_last;
    logic [3:0]         w_bit_inc;
    logic               w_scl;
    logic               w_sda;
    t_out_item          w_result;

    function automatic logic [7:0] byte_to_send(
        input logic [2:0]  idx,
        input logic [6:0]  addr,
        input logic [7:0]  regb,
        input logic [15:0] word,
        input logic        is_wr
    );
        logic [7:0] a;
        a = {addr, 1'b0};
        if (idx == 3'd0) begin
            return a;
        end else if (idx == 3'd1) begin
            return regb;
        end else if (is_wr) begin
            return (idx == 3'd2) ? word[15:8] : word[7:0];
        end else if (idx == 3'd2) begin
            return a | 8'h01;
        end
        return 8'h00;
    endfunction

    assign i_in.ready  = i_rst_n && !r_skid_valid;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;
    assign w_out_fire  = r_out_valid && o_out.ready;

    assign w_len     = (r_phase_len == '0) ? PHASE_W'(1) : r_phase_len;
    assign w_rx      = !r_is_write && (r_byte_index >= 3'd3);
    assign w_n_rx    = !n_is_write && (n_byte_index >= 3'd3);
    assign w_last    = r_is_write ? (r_byte_index >= 3'd3)
                                  : (r_byte_index == 3'd1 || r_byte_index >= 3'd4);
    assign w_bit_inc = r_bit_count + 4'd1;

    // next state
    always_comb begin
        n_state       = r_state;
        n_phase_count = r_phase_count;
        n_bit_count   = r_bit_count;
        n_byte_index  = r_byte_index;
        n_shift       = r_shift;
        n_addr        = r_addr;
        n_reg         = r_reg;
        n_word        = r_word;
        n_read_word   = r_read_word;
        n_nack        = r_nack;
        n_is_write    = r_is_write;
        n_done        = 1'b0;
        if (r_state == ST_IDLE) begin
            if (i_in.data.cmd == CMD_READ || i_in.data.cmd == CMD_WRITE) begin
                n_is_write    = (i_in.data.cmd == CMD_WRITE);
                n_addr        = i_in.data.dev_addr;
                n_reg         = i_in.data.reg_addr;
                n_word        = (i_in.data.cmd == CMD_WRITE) ? i_in.data.write_data : 16'h0000;
                n_nack        = 1'b0;
                n_byte_index  = 3'd0;
                n_bit_count   = 4'd0;
                n_shift       = 8'h00;
                n_phase_count = '0;
                n_state       = ST_START0;
            end
        end else if ({1'b0, r_phase_count} + (PHASE_W+1)'(1) < {1'b0, w_len}) begin
            n_phase_count = r_phase_count + PHASE_W'(1);
        end else begin
            n_phase_count = '0;
            case (r_state)
                ST_START0: n_state = ST_START1;
                ST_START1: n_state = ST_START2;
                ST_START2: n_state = ST_START3;
                ST_START3: begin
                    n_shift     = byte_to_send(r_byte_index, r_addr, r_reg, r_word, r_is_write);
                    n_bit_count = 4'd0;
                    n_state     = ST_BIT0;
                end
                ST_BIT0: n_state = ST_BIT1;
                ST_BIT1: begin
                    // sample the line at the end of SCL high
                    if (w_rx) begin
                        n_shift = {r_shift[6:0], i_in.data.sda_in};
                    end
                    n_state = ST_BIT2;
                end
                ST_BIT2: begin
                    if (!w_rx) begin
                        n_shift = {r_shift[6:0], 1'b0};
                    end
                    n_bit_count = w_bit_inc;
                    n_state     = (w_bit_inc >= 4'd8) ? ST_ACK0 : ST_BIT0;
                end
                ST_ACK0: n_state = ST_ACK1;
                ST_ACK1: begin
                    if (!w_rx && i_in.data.sda_in) begin
                        n_nack = 1'b1;
                    end
                    n_state = ST_ACK2;
                end
                ST_ACK2: begin
                    if (w_rx) begin
                        n_word = (r_byte_index == 3'd3) ? {r_shift, 8'h00}
                                                        : (r_word | {8'h00, r_shift});
                    end
                    if (r_nack || w_last) begin
                        n_state = ST_STOP0;
                    end else begin
                        n_byte_index = r_byte_index + 3'd1;
                        n_shift      = byte_to_send(r_byte_index + 3'd1, r_addr, r_reg,
                                                    r_word, r_is_write);
                        n_bit_count  = 4'd0;
                        n_state      = ST_BIT0;
                    end
                end
                ST_STOP0: n_state = ST_STOP1;
                ST_STOP1: n_state = ST_STOP2;
                ST_STOP2: begin
                    // register pointer sent: restart for the read phase
                    if (!r_is_write && r_byte_index == 3'd1 && !r_nack) begin
                        n_byte_index = 3'd2;
                        n_state      = ST_START0;
                    end else begin
                        n_state = ST_IDLE;
                        n_done  = 1'b1;
                        if (r_nack) begin
                            n_read_word = 16'h0000;
                        end else if (!r_is_write) begin
                            n_read_word = r_word;
                        end
                    end
                end
                default: n_state = ST_IDLE;
            endcase
        end
    end

    // line levels from the state after this tick
    always_comb begin
        case (n_state)
            ST_START0, ST_START1: begin
                w_scl = 1'b1;
                w_sda = 1'b1;
            end
            ST_START2: begin
                w_scl = 1'b1;
                w_sda = 1'b0;
            end
            ST_START3, ST_STOP0: begin
                w_scl = 1'b0;
                w_sda = 1'b0;
            end
            ST_BIT0, ST_BIT1, ST_BIT2: begin
                w_scl = (n_state == ST_BIT1);
                w_sda = w_n_rx ? 1'b1 : n_shift[7];
            end
            ST_ACK0, ST_ACK1, ST_ACK2: begin
                // ACK the MSB of a read, NACK the LSB
                w_scl = (n_state == ST_ACK1);
                w_sda = w_n_rx ? (n_byte_index != 3'd3) : 1'b1;
            end
            ST_STOP1: begin
                w_scl = 1'b1;
                w_sda = 1'b0;
            end
            default: begin
                w_scl = 1'b1;
                w_sda = 1'b1;
            end
        endcase
    end

    always_comb begin
        w_result.scl_release = w_scl;
        w_result.sda_release = w_sda;
        w_result.busy_res    = (n_state != ST_IDLE);
        w_result.done_res    = n_done;
        w_result.nack        = n_nack;
        w_result.read_data   = n_read_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_len <= PHASE_W'(1);
        end else if (i_cfg_we) begin
            r_phase_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase_count <= '0;
            r_bit_count   <= '0;
            r_byte_index  <= '0;
            r_shift       <= '0;
            r_addr        <= '0;
            r_reg         <= '0;
            r_word        <= '0;
            r_read_word   <= '0;
            r_nack        <= 1'b0;
            r_is_write    <= 1'b0;
        end else if (w_in_fire) begin
            r_state       <= n_state;
            r_phase_count <= n_phase_count;
            r_bit_count   <= n_bit_count;
            r_byte_index  <= n_byte_index;
            r_shift       <= n_shift;
            r_addr        <= n_addr;
            r_reg         <= n_reg;
            r_word        <= n_word;
            r_read_word   <= n_read_word;
            r_nack        <= n_nack;
            r_is_write    <= n_is_write;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_in_fire;
            end
        end else if (w_in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (w_in_fire) begin
                r_out_data <= w_result;
            end
        end else if (w_in_fire) begin
            r_skid_data <= w_result;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a transfer while the output register is empty");

    a_idle_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_phase_count == '0)
        else $error("phase counter not cleared while idle");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && n_done |=> r_state == ST_IDLE)
        else $error("transaction end did not return the sequencer to idle");

    a_byte_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_index <= 3'd4 && r_bit_count <= 4'd8)
        else $error("byte or bit counter out of range");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !w_in_fire)
        else $error("transfer taken with both output stages full");

endmodule

@@ dv/i2c_register_transaction_master_checker.sv @@
// Line result predictor and scoreboard for the I2C register transaction master.
`timescale 1ns / 1ps

module i2c_register_transaction_master_checker
    import i2crt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [PHASE_W-1:0] i_cfg_wdata,
    i2crt_in_if                i_tick,
    i2crt_out_if               i_line,
    output int                 o_mismatches,
    output int                 o_pending,
    output t_seq_state         o_seq_state,
    output logic [2:0]         o_byte_index
);

    t_out_item expected_lines[$];
    int mismatch_cnt = 0;
    int line_seen = 0;

    // Predicted sequencer state
    logic [PHASE_W-1:0] phase_len;
    t_seq_state         seq_st;
    logic [PHASE_W-1:0] phase_cnt;
    logic [3:0]         bit_cnt;
    logic [2:0]         byte_idx;
    logic [7:0]         shift_byte;
    logic [6:0]         addr_l;
    logic [7:0]         reg_l;
    logic [15:0]        word_l;
    logic [15:0]        read_word;
    logic               nack_l;
    logic               is_wr;
    logic               scl_l;
    logic               sda_l;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = expected_lines.size();
    assign o_seq_state  = seq_st;
    assign o_byte_index = byte_idx;

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 30) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic logic receiving();
        return !is_wr && (byte_idx >= 3'd3);
    endfunction

    function automatic logic [7:0] byte_on_wire(input logic [2:0] idx);
        logic [7:0] addr_byte;
        addr_byte = {addr_l, 1'b0};
        if (idx == 3'd0) return addr_byte;
        if (idx == 3'd1) return reg_l;
        if (is_wr) return (idx == 3'd2) ? word_l[15:8] : word_l[7:0];
        if (idx == 3'd2) return addr_byte | 8'h01;
        return 8'h00;
    endfunction

    task automatic drive_lines();
        case (seq_st)
            ST_START0, ST_START1: begin
                scl_l = 1'b1; sda_l = 1'b1;
            end
            ST_START2: begin
                scl_l = 1'b1; sda_l = 1'b0;
            end
            ST_START3, ST_STOP0: begin
                scl_l = 1'b0; sda_l = 1'b0;
            end
            ST_BIT0, ST_BIT1, ST_BIT2: begin
                scl_l = (seq_st == ST_BIT1);
                sda_l = receiving() ? 1'b1 : shift_byte[7];
            end
            ST_ACK0, ST_ACK1, ST_ACK2: begin
                // master acknowledges the first read byte and not the second
                scl_l = (seq_st == ST_ACK1);
                sda_l = receiving() ? (byte_idx != 3'd3) : 1'b1;
            end
            ST_STOP1: begin
                scl_l = 1'b1; sda_l = 1'b0;
            end
            default: begin
                scl_l = 1'b1; sda_l = 1'b1;
            end
        endcase
    endtask

    task automatic advance_phase(input logic sda, output logic done);
        logic last_byte;
        done = 1'b0;
        case (seq_st)
            ST_START0, ST_START1, ST_START2: seq_st = t_seq_state'(seq_st + 4'd1);
            ST_START3: begin
                shift_byte = byte_on_wire(byte_idx);
                bit_cnt    = '0;
                seq_st     = ST_BIT0;
            end
            ST_BIT0: seq_st = ST_BIT1;
            ST_BIT1: begin
                if (receiving()) shift_byte = {shift_byte[6:0], sda};
                seq_st = ST_BIT2;
            end
            ST_BIT2: begin
                if (!receiving()) shift_byte = {shift_byte[6:0], 1'b0};
                bit_cnt++;
                seq_st = (bit_cnt >= 4'd8) ? ST_ACK0 : ST_BIT0;
            end
            ST_ACK0: seq_st = ST_ACK1;
            ST_ACK1: begin
                if (!receiving() && sda) nack_l = 1'b1;
                seq_st = ST_ACK2;
            end
            ST_ACK2: begin
                if (receiving()) begin
                    if (byte_idx == 3'd3) word_l = {shift_byte, 8'h00};
                    else                  word_l = word_l | {8'h00, shift_byte};
                end
                if (is_wr) last_byte = (byte_idx >= 3'd3);
                else       last_byte = (byte_idx == 3'd1) || (byte_idx >= 3'd4);
                if (nack_l || last_byte) begin
                    seq_st = ST_STOP0;
                end else begin
                    byte_idx++;
                    shift_byte = byte_on_wire(byte_idx);
                    bit_cnt    = '0;
                    seq_st     = ST_BIT0;
                end
            end
            ST_STOP0: seq_st = ST_STOP1;
            ST_STOP1: seq_st = ST_STOP2;
            ST_STOP2: begin
                // a read restarts after the register pointer is written
                if (!is_wr && byte_idx == 3'd1 && !nack_l) begin
                    byte_idx = 3'd2;
                    seq_st   = ST_START0;
                end else begin
                    seq_st = ST_IDLE;
                    if (nack_l)      read_word = '0;
                    else if (!is_wr) read_word = word_l;
                    done = 1'b1;
                end
            end
            default: seq_st = ST_IDLE;
        endcase
    endtask

    task automatic sequence_tick(input t_in_item it);
        logic        done;
        int unsigned len;
        t_out_item   line;
        done = 1'b0;
        if (seq_st == ST_IDLE) begin
            if (it.cmd == CMD_READ || it.cmd == CMD_WRITE) begin
                is_wr      = (it.cmd == CMD_WRITE);
                addr_l     = it.dev_addr;
                reg_l      = it.reg_addr;
                word_l     = is_wr ? it.write_data : 16'h0000;
                nack_l     = 1'b0;
                byte_idx   = '0;
                bit_cnt    = '0;
                shift_byte = '0;
                phase_cnt  = '0;
                seq_st     = ST_START0;
            end
        end else begin
            len = (phase_len == '0) ? 1 : phase_len;
            if (int'(phase_cnt) + 1 < len) begin
                phase_cnt++;
            end else begin
                phase_cnt = '0;
                advance_phase(it.sda_in, done);
            end
        end
        drive_lines();
        line.scl_release = scl_l;
        line.sda_release = sda_l;
        line.busy_res    = (seq_st != ST_IDLE);
        line.done_res    = done;
        line.nack        = nack_l;
        line.read_data   = read_word;
        expected_lines.push_back(line);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      line_seen, name, got, want));
        end
    endtask

    task automatic check_line(input t_out_item got);
        t_out_item want;
        if (expected_lines.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no tick outstanding", line_seen));
        end else begin
            want = expected_lines.pop_front();
            compare_field("scl_release", 16'(got.scl_release), 16'(want.scl_release));
            compare_field("sda_release", 16'(got.sda_release), 16'(want.sda_release));
            compare_field("busy_res",    16'(got.busy_res),    16'(want.busy_res));
            compare_field("done_res",    16'(got.done_res),    16'(want.done_res));
            compare_field("nack",        16'(got.nack),        16'(want.nack));
            compare_field("read_data",   got.read_data,        want.read_data);
        end
        line_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase_len  = PHASE_W'(1);
            seq_st     = ST_IDLE;
            phase_cnt  = '0;
            bit_cnt    = '0;
            byte_idx   = '0;
            shift_byte = '0;
            addr_l     = '0;
            reg_l      = '0;
            word_l     = '0;
            read_word  = '0;
            nack_l     = 1'b0;
            is_wr      = 1'b0;
            scl_l      = 1'b1;
            sda_l      = 1'b1;
            expected_lines.delete();
        end else begin
            // results are registered after their tick, so check before predicting
            if (i_line.valid && i_line.ready) check_line(i_line.data);
            if (i_tick.valid && i_tick.ready) sequence_tick(i_tick.data);
            // a register write takes effect for the ticks after this edge
            if (i_cfg_we) phase_len = i_cfg_wdata;
        end
    end

endmodule

@@ dv/i2c_register_transaction_master_tb.sv @@
// Stimulus, bus responder and verdict for the I2C register transaction master.
`timescale 1ns / 1ps

module i2c_register_transaction_master_tb;
    import i2crt_pkg::*;

    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [2:0] NO_NACK     = 3'd7;
    localparam int         DATA_ZEROS  = 0;
    localparam int         DATA_ONES   = 1;
    localparam int         DATA_RANDOM = 2;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [PHASE_W-1:0] i_cfg_wdata;

    i2crt_in_if  tick_if();
    i2crt_out_if line_if();

    int         mismatches;
    int         pending;
    t_seq_state seq_state_pred;
    logic [2:0] byte_pred;

    int         cycles      = 0;
    int         burst_left  = 0;
    int         stall_mode  = 0;
    int         mode_left   = 0;
    int         stall_left  = 0;
    logic [2:0] nack_at     = NO_NACK;
    int         data_mode   = DATA_RANDOM;

    i2c_register_transaction_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (tick_if),
        .o_out       (line_if)
    );

    i2c_register_transaction_master_checker line_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_tick       (tick_if),
        .i_line       (line_if),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_seq_state  (seq_state_pred),
        .o_byte_index (byte_pred)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver back-pressure: switch between stall patterns every so often
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 300);
        end
        mode_left--;
        case (stall_mode)
            0: line_if.ready <= 1'b1;
            1: line_if.ready <= 1'($urandom_range(0, 1));
            2: line_if.ready <= (mode_left % 5) != 0;
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    line_if.ready <= 1'b0;
                end else begin
                    line_if.ready <= 1'b1;
                    if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 30);
                end
            end
        endcase
    end

    // Target side of SDA: acknowledge unless told to refuse this byte
    function automatic logic line_response();
        case (seq_state_pred)
            ST_ACK1: return byte_pred == nack_at;
            ST_BIT0, ST_BIT1, ST_BIT2: begin
                if (data_mode == DATA_ZEROS) return 1'b0;
                if (data_mode == DATA_ONES)  return 1'b1;
                return 1'($urandom_range(0, 1));
            end
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // Returns at the falling edge after the transfer
    task automatic send_tick(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                tick_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                     : $urandom_range(1, 48);
        end
        tick_if.data  <= it;
        tick_if.valid <= 1'b1;
        do @(posedge i_clk); while (!tick_if.ready);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic hold_until_drained();
        tick_if.valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_phase_len(input logic [PHASE_W-1:0] len);
        hold_until_drained();
        i_cfg_wdata <= len;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic fill_ignored_fields(inout t_in_item it);
        it.dev_addr   = 7'($urandom);
        it.reg_addr   = 8'($urandom);
        it.write_data = 16'($urandom);
    endtask

    // Issue one command, then tick until the sequencer is idle again
    task automatic run_transaction(input logic [1:0] cmd, input logic [6:0] dev,
                                   input logic [7:0] rg, input logic [15:0] wd,
                                   input logic [2:0] refuse_byte, input int mode,
                                   input bit starts_while_busy);
        t_in_item it;
        nack_at       = refuse_byte;
        data_mode     = mode;
        it.cmd        = cmd;
        it.dev_addr   = dev;
        it.reg_addr   = rg;
        it.write_data = wd;
        it.sda_in     = line_response();
        send_tick(it);
        while (seq_state_pred != ST_IDLE) begin
            it.cmd = starts_while_busy ? (($urandom_range(0, 1) == 0) ? CMD_READ : CMD_WRITE)
                                       : CMD_TICK;
            fill_ignored_fields(it);
            it.sda_in = line_response();
            send_tick(it);
        end
    endtask

    // Send a fixed number of ticks; a transaction may still be running at the end
    task automatic run_random(input int n_ticks);
        t_in_item it;
        int       sent;
        int       pause_at;
        sent     = 0;
        pause_at = $urandom_range(0, n_ticks - 1);
        while (sent < n_ticks) begin
            if (sent == pause_at) hold_until_drained();
            if (seq_state_pred == ST_IDLE) begin
                // pick the target's behavior for the next transaction
                nack_at   = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 4)) : NO_NACK;
                data_mode = $urandom_range(DATA_ZEROS, DATA_RANDOM);
                case ($urandom_range(0, 7))
                    0:       it.cmd = CMD_TICK;
                    1:       it.cmd = CMD_UNUSED;
                    2, 3, 4: it.cmd = CMD_READ;
                    default: it.cmd = CMD_WRITE;
                endcase
            end else begin
                it.cmd = 2'($urandom_range(0, 3));
            end
            fill_ignored_fields(it);
            it.sda_in = line_response();
            send_tick(it);
            sent++;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        tick_if.valid = 1'b0;
        tick_if.data  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: plain ticks, field extremes, refused bytes, starts while busy
        run_transaction(CMD_TICK, 7'h00, 8'h00, 16'h0000, NO_NACK, DATA_ZEROS, 1'b0);
        run_transaction(CMD_UNUSED, 7'h7F, 8'hFF, 16'hFFFF, NO_NACK, DATA_ONES, 1'b0);
        run_transaction(CMD_WRITE, 7'h7F, 8'hFF, 16'hFFFF, NO_NACK, DATA_ONES, 1'b1);
        run_transaction(CMD_READ, 7'h55, 8'hA5, 16'h1234, NO_NACK, DATA_RANDOM, 1'b1);
        run_transaction(CMD_WRITE, 7'h2A, 8'h5A, 16'hA55A, 3'd3, DATA_RANDOM, 1'b0);
        run_transaction(CMD_WRITE, 7'h40, 8'h7E, 16'h7FFE, 3'd1, DATA_RANDOM, 1'b0);
        run_transaction(CMD_READ, 7'h3C, 8'hC3, 16'h0000, 3'd0, DATA_RANDOM, 1'b0);
        run_transaction(CMD_READ, 7'h0F, 8'hF0, 16'h0000, 3'd2, DATA_RANDOM, 1'b1);

        run_random(150);
        write_phase_len(PHASE_W'(0));
        run_random(100);
        write_phase_len(PHASE_W'(2));
        run_random(120);
        write_phase_len(PHASE_W'(3));
        run_random(80);
        // longest phase length: a short stretch, then cut it back mid-phase
        write_phase_len(PHASE_W'(1023));
        run_random(30);
        write_phase_len(PHASE_W'(1));
        run_random(100);

        hold_until_drained();
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ i2c_register_transaction_master.f @@
hw/rtl/i2crt_pkg.sv
hw/rtl/i2crt_if.sv
hw/rtl/i2c_register_transaction_master.sv
dv/i2c_register_transaction_master_checker.sv
dv/i2c_register_transaction_master_tb.sv
